/* rtl/dqe_pkg.sv */
// Shared types and constants for the DNS query name encoder.
package dqe_pkg;

  localparam int unsigned LabelDepth  = 64;
  localparam int unsigned LabelAw     = $clog2(LabelDepth);
  localparam int unsigned MemDepth    = 2 * LabelDepth;
  localparam int unsigned MemAw       = $clog2(MemDepth);
  localparam int unsigned CmdDepth    = 2;
  localparam int unsigned CmdAw       = $clog2(CmdDepth);

  localparam logic [LabelAw-1:0] LabelMax = LabelAw'(63);
  localparam logic [8:0]         NameMax  = 9'd255;

  localparam logic [LabelAw-1:0] HdrLastPos = LabelAw'(12 - 1);
  localparam logic [LabelAw-1:0] TrlLastPos = LabelAw'(5 - 1);

  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharBsl   = 8'h5C;
  localparam logic [7:0] FlagsRd   = 8'h01;
  localparam logic [7:0] CountOne  = 8'h01;
  localparam logic [7:0] ClassInLo = 8'h01;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StEmptyLabel = 2'd1,
    StLabelLong  = 2'd2,
    StNameLong   = 2'd3
  } status_e;

  typedef struct packed {
    logic               hdr;
    logic [15:0]        id;
    logic               flush;
    logic [LabelAw-1:0] cnt;
    logic               bank;
    logic               trl;
    logic [15:0]        rtype;
    status_e            status;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

/* rtl/dqe_front.sv */
// Front end: accepts name characters, tracks labels and errors, issues commands.
module dqe_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       name_char_i,
  input  logic             name_end_i,
  input  logic [15:0]      query_id_i,
  input  logic [15:0]      record_type_i,
  input  logic             fifo_full_i,
  output logic             cmd_push_o,
  output dqe_pkg::cmd_t    cmd_o,
  output dqe_pkg::mem_wr_t wr_o,
  input  dqe_pkg::rel_t    rel_i
);
  import dqe_pkg::*;

  logic               started_q;
  logic [LabelAw-1:0] cnt_q;
  logic [8:0]         enc_q;
  logic               esc_q;
  status_e            err_q;
  logic [15:0]        type_q;
  logic               bank_q;
  logic [1:0]         busy_q, busy_d;

  logic               acc, first, esc_c, is_dot, set_esc, app, app_ok, flush, emit;
  logic [LabelAw-1:0] cnt_c, cnt_a;
  logic [8:0]         enc_c, enc_f;
  logic [9:0]         enc_sum;
  status_e            err_c, err_a, err_f;

  assign full = fifo_full_i | busy_q[bank_q];
  assign acc  = push & ~full;

  always_comb begin
    first   = ~started_q;
    cnt_c   = first ? '0 : cnt_q;
    enc_c   = first ? '0 : enc_q;
    esc_c   = first ? 1'b0 : esc_q;
    err_c   = first ? StOk : err_q;
    is_dot  = ~esc_c & (name_char_i == CharDot);
    set_esc = ~esc_c & (name_char_i == CharBsl) & ~name_end_i;
    app     = ~is_dot & ~set_esc;
    app_ok  = app & (err_c == StOk) & (cnt_c < LabelMax);
    cnt_a   = cnt_c + LabelAw'(app_ok);
    err_a   = err_c;
    if (app && err_c == StOk && cnt_c >= LabelMax) begin
      err_a = StLabelLong;
    end else if (is_dot && cnt_c == '0 && !(first && name_end_i) && err_c == StOk) begin
      err_a = StEmptyLabel;
    end
    flush   = (is_dot | name_end_i) & (cnt_a != '0);
    emit    = flush & (err_a == StOk);
    enc_sum = {1'b0, enc_c} + {{(10 - LabelAw){1'b0}}, cnt_a} + 10'd1;
    enc_f   = enc_c;
    if (emit) begin
      enc_f = enc_sum[9] ? 9'h1FF : enc_sum[8:0];
    end
    err_f = err_a;
    if (name_end_i && err_a == StOk && enc_f >= NameMax) begin
      err_f = StNameLong;
    end
  end

  assign cmd_push_o   = acc & (first | emit | name_end_i);
  assign cmd_o.hdr    = first;
  assign cmd_o.id     = query_id_i;
  assign cmd_o.flush  = emit;
  assign cmd_o.cnt    = cnt_a;
  assign cmd_o.bank   = bank_q;
  assign cmd_o.trl    = name_end_i;
  assign cmd_o.rtype  = first ? record_type_i : type_q;
  assign cmd_o.status = err_f;

  assign wr_o.en   = acc & app_ok;
  assign wr_o.addr = {bank_q, cnt_c};
  assign wr_o.data = name_char_i;

  always_comb begin
    busy_d = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (acc && emit) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      cnt_q     <= '0;
      enc_q     <= '0;
      esc_q     <= 1'b0;
      err_q     <= StOk;
      type_q    <= '0;
      bank_q    <= 1'b0;
      busy_q    <= '0;
    end else begin
      busy_q <= busy_d;
      if (acc) begin
        if (first) begin
          type_q <= record_type_i;
        end
        if (emit) begin
          bank_q <= ~bank_q;
        end
        if (name_end_i) begin
          started_q <= 1'b0;
          cnt_q     <= '0;
          enc_q     <= '0;
          esc_q     <= 1'b0;
          err_q     <= StOk;
        end else begin
          started_q <= 1'b1;
          cnt_q     <= flush ? '0 : cnt_a;
          enc_q     <= enc_f;
          esc_q     <= set_esc;
          err_q     <= err_a;
        end
      end
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_o |-> !fifo_full_i) else $error("command pushed into a full queue");

  a_write_free_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> !busy_q[bank_q]) else $error("label write into a draining bank");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> (cnt_q == '0 && err_q == StOk && !esc_q))
    else $error("name state not cleared between names");

endmodule

/* rtl/dqe_cmd_fifo.sv */
// Short command queue between the front and back ends.
module dqe_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dqe_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dqe_pkg::cmd_t data_o
);
  import dqe_pkg::*;

  cmd_t             ent_q [CmdDepth];
  logic [CmdAw-1:0] wp_q, rp_q;
  logic [CmdAw:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == (CmdAw + 1)'(CmdDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = ent_q[rp_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (CmdAw + 1)'(do_push) - (CmdAw + 1)'(do_pop);
    end
  end

endmodule

/* rtl/dqe_back.sv */
// Back end: label memory, byte sequencer and word packer with output register.
module dqe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  dqe_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  dqe_pkg::mem_wr_t wr_i,
  output dqe_pkg::rel_t    rel_o,
  input  logic             pop,
  output logic             empty,
  output logic [15:0]      out_word_o,
  output logic [1:0]       out_bytes_o,
  output logic             out_last_o,
  output logic [1:0]       status_o
);
  import dqe_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhHdr  = 2'd1;
  localparam logic [1:0] PhLbl  = 2'd2;
  localparam logic [1:0] PhTrl  = 2'd3;

  logic [7:0]         mem [MemDepth];
  logic [7:0]         rd_q;
  cmd_t               cmd_q;
  logic [1:0]         phase_q, phase_d;
  logic [LabelAw-1:0] pos_q;
  logic [7:0]         held_q;
  logic               held_v_q;
  logic               ov_q;
  logic [15:0]        word_q;
  logic [1:0]         bytes_q;
  logic               last_q;
  status_e            stat_q;

  logic [7:0]         cur;
  logic [LabelAw-1:0] last_pos;
  logic               at_end, fin, space, adv, load, rd_en;

  function automatic logic [1:0] first_phase(input logic hdr, input logic flush,
                                             input logic trl);
    logic [1:0] ph;
    ph = PhIdle;
    if (hdr) begin
      ph = PhHdr;
    end else if (flush) begin
      ph = PhLbl;
    end else if (trl) begin
      ph = PhTrl;
    end
    return ph;
  endfunction

  always_comb begin
    cur      = 8'h00;
    last_pos = '0;
    case (phase_q)
      PhHdr: begin
        last_pos = HdrLastPos;
        case (pos_q)
          LabelAw'(0): cur = cmd_q.id[15:8];
          LabelAw'(1): cur = cmd_q.id[7:0];
          LabelAw'(2): cur = FlagsRd;
          LabelAw'(5): cur = CountOne;
          default:     cur = 8'h00;
        endcase
      end
      PhLbl: begin
        last_pos = cmd_q.cnt;
        cur      = (pos_q == '0) ? 8'(cmd_q.cnt) : rd_q;
      end
      PhTrl: begin
        last_pos = TrlLastPos;
        case (pos_q)
          LabelAw'(1): cur = cmd_q.rtype[15:8];
          LabelAw'(2): cur = cmd_q.rtype[7:0];
          LabelAw'(4): cur = ClassInLo;
          default:     cur = 8'h00;
        endcase
      end
      default: begin
        cur      = 8'h00;
        last_pos = '0;
      end
    endcase
  end

  assign at_end    = pos_q == last_pos;
  assign fin       = (phase_q == PhTrl) & at_end;
  assign space     = ~ov_q | pop;
  assign adv       = (phase_q != PhIdle) & (~(held_v_q | fin) | space);
  assign load      = (phase_q == PhIdle) & cmd_valid_i;
  assign cmd_pop_o = load;
  assign rd_en     = adv & (phase_q == PhLbl);

  assign rel_o.valid = adv & (phase_q == PhLbl) & at_end;
  assign rel_o.bank  = cmd_q.bank;

  always_comb begin
    phase_d = phase_q;
    if (load) begin
      phase_d = first_phase(cmd_i.hdr, cmd_i.flush, cmd_i.trl);
    end else if (adv && at_end) begin
      case (phase_q)
        PhHdr:   phase_d = first_phase(1'b0, cmd_q.flush, cmd_q.trl);
        PhLbl:   phase_d = first_phase(1'b0, 1'b0, cmd_q.trl);
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      rd_q <= mem[{cmd_q.bank, pos_q}];
    end
    if (load) begin
      cmd_q <= cmd_i;
    end
    if (adv && !held_v_q && !fin) begin
      held_q <= cur;
    end
    if (adv && (held_v_q || fin)) begin
      word_q  <= held_v_q ? {held_q, cur} : {cur, 8'h00};
      bytes_q <= held_v_q ? 2'd2 : 2'd1;
      last_q  <= fin;
      stat_q  <= fin ? cmd_q.status : StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      pos_q    <= '0;
      held_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load || (adv && at_end)) begin
        pos_q <= '0;
      end else if (adv) begin
        pos_q <= pos_q + LabelAw'(1);
      end
      if (adv) begin
        held_v_q <= ~held_v_q & ~fin;
      end
      if (adv && (held_v_q || fin)) begin
        ov_q <= 1'b1;
      end else if (pop) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign empty       = ~ov_q;
  assign out_word_o  = word_q;
  assign out_bytes_o = bytes_q;
  assign out_last_o  = last_q;
  assign status_o    = stat_q;

  a_label_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhLbl |-> pos_q <= cmd_q.cnt) else $error("label position overrun");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && bytes_q == 2'd1) |-> last_q) else $error("single-byte word before packet end");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> phase_q != PhIdle) else $error("command taken with no work");

endmodule

/* rtl/dns_query_name_encoder.sv */
// Top level of the DNS query name encoder: front end, command queue, back end.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------------
//   input    | push / full        | name_char_i, name_end_i, query_id_i, record_type_i
//   result   | empty / pop        | out_word_o, out_bytes_o, out_last_o, status_o
//
// The front end takes one character per cycle while the command queue has room and
// the label bank it fills is not still being read out.
// The back end takes a command when idle and sequences its packet bytes (header, labels,
// trailer), packing them in pairs into result words; a closing odd byte leaves alone in
// a single-byte word. A finished word waits while the output register holds an unpopped one.
// Two label banks let the next label fill while the previous one drains.
// Reset clears all control state at once; no clearing pass is needed.
module dns_query_name_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  name_char_i,
  input  logic        name_end_i,
  input  logic [15:0] query_id_i,
  input  logic [15:0] record_type_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_word_o,
  output logic [1:0]  out_bytes_o,
  output logic        out_last_o,
  output logic [1:0]  status_o
);
  import dqe_pkg::*;

  logic    cmd_push, fifo_full, cmd_valid, cmd_pop;
  cmd_t    cmd_in, cmd_out;
  mem_wr_t wr;
  rel_t    rel;

  dqe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .name_char_i   (name_char_i),
    .name_end_i    (name_end_i),
    .query_id_i    (query_id_i),
    .record_type_i (record_type_i),
    .fifo_full_i   (fifo_full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in),
    .wr_o          (wr),
    .rel_i         (rel)
  );

  dqe_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (fifo_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  dqe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .wr_i        (wr),
    .rel_o       (rel),
    .pop         (pop),
    .empty       (empty),
    .out_word_o  (out_word_o),
    .out_bytes_o (out_bytes_o),
    .out_last_o  (out_last_o),
    .status_o    (status_o)
  );

endmodule

/* test/dns_query_name_encoder_test.sv */
// Testbench for the DNS query name encoder: directed and random name streams checked against a predictor.
`timescale 1ns / 1ps

module dns_query_name_encoder_test;
  import dqe_pkg::*;

  localparam int StallLimit = 4000;
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles = 100;

  typedef struct {
    bit [7:0]  ch;
    bit        fin;
    bit [15:0] id;
    bit [15:0] rtype;
  } name_item_t;

  typedef struct {
    bit [15:0] word;
    bit [1:0]  nbytes;
    bit        last;
    status_e   status;
  } packet_word_t;

  typedef bit [7:0] char_q_t[$];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  name_char_i = 8'h00;
  logic        name_end_i = 1'b0;
  logic [15:0] query_id_i = 16'h0000;
  logic [15:0] record_type_i = 16'h0000;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] out_word_o;
  logic [1:0]  out_bytes_o;
  logic        out_last_o;
  logic [1:0]  status_o;

  dns_query_name_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .name_char_i   (name_char_i),
    .name_end_i    (name_end_i),
    .query_id_i    (query_id_i),
    .record_type_i (record_type_i),
    .empty         (empty),
    .pop           (pop),
    .out_word_o    (out_word_o),
    .out_bytes_o   (out_bytes_o),
    .out_last_o    (out_last_o),
    .status_o      (status_o)
  );

  always #1 clk_i = ~clk_i;

  name_item_t   pending_items[$];
  packet_word_t packet_words[$];

  int error_count = 0;
  int chars_queued = 0;
  int chars_sent = 0;
  int words_checked = 0;
  int status_count[4] = '{0, 0, 0, 0};
  int hold_requests = 0;
  int holds_done = 0;

  // Predictor state for the name being encoded
  bit [7:0]    lbl_buf[64];
  int unsigned lbl_len = 0;
  int unsigned name_len = 0;
  bit          esc_pend = 1'b0;
  bit          in_name = 1'b0;
  status_e     name_err = StOk;
  bit [7:0]    odd_byte = 8'h00;
  bit          odd_valid = 1'b0;
  bit [15:0]   qtype = 16'h0000;

  function automatic void emit_word(bit [15:0] w, bit [1:0] n);
    packet_word_t r;
    r.word = w;
    r.nbytes = n;
    r.last = 1'b0;
    r.status = StOk;
    packet_words.insert(packet_words.size(), r);
  endfunction

  function automatic void put_byte(bit [7:0] b);
    if (odd_valid) begin
      emit_word({odd_byte, b}, 2'd2);
      odd_valid = 1'b0;
      odd_byte = 8'h00;
    end else begin
      odd_byte = b;
      odd_valid = 1'b1;
    end
  endfunction

  function automatic void flag_error(status_e kind);
    if (name_err == StOk) name_err = kind;
  endfunction

  function automatic void add_label_char(bit [7:0] c);
    if (name_err == StOk) begin
      if (lbl_len >= LabelMax) begin
        flag_error(StLabelLong);
      end else begin
        lbl_buf[lbl_len] = c;
        lbl_len++;
      end
    end
  endfunction

  function automatic void flush_label();
    if (name_err == StOk) begin
      put_byte(8'(lbl_len));
      for (int i = 0; i < lbl_len; i++) put_byte(lbl_buf[i]);
      name_len += lbl_len + 1;
      if (name_len > 511) name_len = 511;
    end
    lbl_len = 0;
  endfunction

  function automatic void clear_name();
    lbl_len = 0;
    name_len = 0;
    esc_pend = 1'b0;
    in_name = 1'b0;
    name_err = StOk;
    odd_byte = 8'h00;
    odd_valid = 1'b0;
  endfunction

  function automatic void encode_char(name_item_t it);
    bit first;
    packet_word_t tail;
    first = !in_name;
    if (first) begin
      clear_name();
      in_name = 1'b1;
      qtype = it.rtype;
      put_byte(it.id[15:8]);
      put_byte(it.id[7:0]);
      put_byte(FlagsRd);
      put_byte(8'h00);
      put_byte(8'h00);
      put_byte(CountOne);
      repeat (6) put_byte(8'h00);
    end
    if (esc_pend) begin
      esc_pend = 1'b0;
      add_label_char(it.ch);
    end else if (it.ch == CharBsl && !it.fin) begin
      esc_pend = 1'b1;
    end else if (it.ch == CharDot) begin
      if (lbl_len == 0) begin
        if (!(first && it.fin)) flag_error(StEmptyLabel);
      end else begin
        flush_label();
      end
    end else begin
      add_label_char(it.ch);
    end
    if (it.fin) begin
      if (lbl_len > 0) flush_label();
      if (name_err == StOk && name_len + 1 > NameMax) flag_error(StNameLong);
      put_byte(8'h00);
      put_byte(qtype[15:8]);
      put_byte(qtype[7:0]);
      put_byte(8'h00);
      put_byte(ClassInLo);
      if (odd_valid) begin
        emit_word({odd_byte, 8'h00}, 2'd1);
        odd_valid = 1'b0;
      end
      tail = packet_words.pop_back();
      tail.last = 1'b1;
      tail.status = name_err;
      packet_words.insert(packet_words.size(), tail);
      clear_name();
    end
  endfunction

  // Sender
  name_item_t cur_item;
  int tx_gap = 0;
  bit tx_burst = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        encode_char(cur_item);
        chars_sent++;
      end
      if (!push || !full) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          name_char_i <= cur_item.ch;
          name_end_i <= cur_item.fin;
          query_id_i <= cur_item.id;
          record_type_i <= cur_item.rtype;
          push <= 1'b1;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 11);
          if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver
  packet_word_t exp_word;
  int rx_gap = 0;
  bit rx_burst = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (packet_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, got %h bytes %0d last %0b status %0d",
                   $realtime, out_word_o, out_bytes_o, out_last_o, status_o);
          error_count++;
        end else begin
          exp_word = packet_words.pop_front();
          if (out_word_o !== exp_word.word || out_bytes_o !== exp_word.nbytes ||
              out_last_o !== exp_word.last || status_o !== exp_word.status) begin
            $display("%0t: expected word %h bytes %0d last %0b status %0d, got %h %0d %0b %0d",
                     $realtime, exp_word.word, exp_word.nbytes, exp_word.last, exp_word.status,
                     out_word_o, out_bytes_o, out_last_o, status_o);
            error_count++;
          end
        end
        words_checked++;
        if (out_last_o === 1'b1) status_count[status_o]++;
        rx_gap = rx_burst ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      end
      if (hold_requests != holds_done) begin
        holds_done++;
        rx_gap = HoldOffCycles;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog
  int stall_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $realtime, StallLimit);
        $display("dns_query_name_encoder test failed");
        $finish;
      end
    end
  end

  task automatic add_char(bit [7:0] c, bit fin, bit [15:0] id, bit [15:0] rt);
    name_item_t it;
    it.ch = c;
    it.fin = fin;
    it.id = id;
    it.rtype = rt;
    pending_items.insert(pending_items.size(), it);
    chars_queued++;
  endtask

  task automatic queue_text(string s, bit [15:0] id, bit [15:0] rt);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1, id, rt);
  endtask

  task automatic queue_chars(char_q_t chars);
    for (int i = 0; i < chars.size(); i++)
      add_char(chars[i], i == chars.size() - 1, 16'($urandom), 16'($urandom));
  endtask

  function automatic void push_label_char(ref char_q_t chars);
    bit [7:0] c;
    if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
    else c = 8'h61 + 8'($urandom_range(0, 25));
    if (c == CharDot || c == CharBsl || $urandom_range(0, 11) == 0) begin
      chars.insert(chars.size(), CharBsl);
    end
    chars.insert(chars.size(), c);
  endfunction

  function automatic void build_name(ref char_q_t chars, input int nlab, input int min_len,
                                     input int max_len);
    for (int l = 0; l < nlab; l++) begin
      if (l > 0) chars.insert(chars.size(), CharDot);
      repeat ($urandom_range(min_len, max_len)) push_label_char(chars);
    end
  endfunction

  task automatic queue_random_phase(int budget, bit long_name);
    char_q_t chars;
    int start;
    int special_at;
    bit special_done;
    start = chars_queued;
    special_at = $urandom_range(10, budget - 10);
    special_done = 1'b0;
    while (chars_queued - start < budget) begin
      chars = {};
      if (!special_done && chars_queued - start >= special_at) begin
        special_done = 1'b1;
        if (long_name) begin
          build_name(chars, 2, 40, 63);
        end else begin
          repeat (64) chars.insert(chars.size(), 8'h61 + 8'($urandom_range(0, 25)));
          chars.insert(chars.size(), CharDot);
          chars.insert(chars.size(), 8'h62);
        end
        budget += chars.size();
      end else if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: chars.insert(chars.size(), CharDot);
            1: chars.insert(chars.size(), CharBsl);
            default: chars.insert(chars.size(), 8'($urandom_range(0, 255)));
          endcase
        end
      end else begin
        if ($urandom_range(0, 7) == 0) build_name(chars, $urandom_range(1, 4), 9, 20);
        else build_name(chars, $urandom_range(1, 4), 1, 8);
        if ($urandom_range(0, 3) == 0) chars.insert(chars.size(), CharDot);
      end
      queue_chars(chars);
    end
  endtask

  task automatic wait_drained();
    while (chars_sent != chars_queued || packet_words.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_text(".", 16'hFFFF, 16'hFFFF);
    queue_text("a.", 16'h0000, 16'h0000);
    queue_text(".a", 16'h1234, 16'h0001);
    queue_text("..", 16'h8001, 16'h001C);
    queue_text("a..b", 16'h5A5A, 16'hA5A5);
    queue_text("a\\.b", 16'h00FF, 16'hFF00);
    queue_text("\\\\", 16'h7FFF, 16'h8000);
    queue_text("b\\", 16'hC3C3, 16'h0005);
    add_char(8'hFF, 1'b1, 16'hFFFF, 16'h0000);
    add_char(8'h00, 1'b1, 16'h0000, 16'hFFFF);
    wait_drained();

    hold_requests++;
    queue_random_phase(55, 1'b0);
    wait_drained();
    queue_random_phase(45, 1'b1);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d characters, checked %0d words in %0d packets",
             chars_sent, words_checked,
             status_count[0] + status_count[1] + status_count[2] + status_count[3]);
    $display("Status: ok %0d, empty label %0d, label too long %0d, name too long %0d",
             status_count[StOk], status_count[StEmptyLabel], status_count[StLabelLong],
             status_count[StNameLong]);
    if (error_count == 0) begin
      $display("dns_query_name_encoder test passed");
    end else begin
      $display("dns_query_name_encoder test failed");
    end
    $finish;
  end

endmodule
